// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers. They compile to nothing under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every rising edge outside reset.
`define VCS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never be seen at a rising edge outside reset.
`define VCS_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define VCS_ASSERT(lbl, clk, rst_n, prop, msg)
`define VCS_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

// File: design/vcs_pkg.sv
// ----------------------------------------------------------------------------
// vcs_pkg
// Widths, angle constants, the CORDIC arctangent table and shared types.
// ----------------------------------------------------------------------------
package vcs_pkg;

    localparam int POS_W         = 16;
    localparam int HEAD_W        = 15;
    localparam int DIST_W        = 33;
    localparam int ANG_W         = 14;
    localparam int CFG_IDX_W     = 2;
    localparam int POS_FRAC_BITS = 6;
    localparam int CORDIC_STAGES_DEF = 16;

    // Signed position difference, squared magnitude, CORDIC datapath.
    localparam int DIFF_W      = POS_W + 1;
    localparam int SQ_W        = 2 * POS_W;
    localparam int CW          = 28;
    localparam int ZW          = 24;
    localparam int AW          = 17;
    localparam int GUARD_SHIFT = 8;
    localparam int ACC_EXTRA   = 8;

    localparam int FULL_TURN = 23040;
    localparam int HALF_TURN = 11520;

    // Quarter turn in the accumulator's 1/16384 degree units.
    localparam logic signed [ZW-1:0] Z_QUARTER = ZW'(90 * 64 * (1 << ACC_EXTRA));

    // Ten square pixels in the squared-distance format.
    localparam logic [DIST_W-1:0] NEAR_LIMIT = DIST_W'(10) << (2 * POS_FRAC_BITS);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_DIST_SQ = 2'd0,
        CFG_CONE_LIMIT  = 2'd1,
        CFG_TURN_STEP   = 2'd2
    } t_cfg_idx;

    // Control that rides along the pipeline next to the CORDIC vector.
    typedef struct packed {
        logic [HEAD_W-1:0] head_in;
        logic [HEAD_W-1:0] head;
        logic              dist_ok;
    } t_side;

    // atan(2^-i) in 1/16384 degree.
    function automatic logic signed [ZW-1:0] atan_val(input int idx);
        logic signed [ZW-1:0] v;
        case (idx)
            0:  v = ZW'(737280);
            1:  v = ZW'(435242);
            2:  v = ZW'(229970);
            3:  v = ZW'(116736);
            4:  v = ZW'(58595);
            5:  v = ZW'(29326);
            6:  v = ZW'(14667);
            7:  v = ZW'(7334);
            8:  v = ZW'(3667);
            9:  v = ZW'(1833);
            10: v = ZW'(917);
            11: v = ZW'(458);
            12: v = ZW'(229);
            13: v = ZW'(115);
            14: v = ZW'(57);
            15: v = ZW'(29);
            16: v = ZW'(14);
            17: v = ZW'(7);
            18: v = ZW'(4);
            19: v = ZW'(2);
            20: v = ZW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: design/vcs_front.sv
// ----------------------------------------------------------------------------
// vcs_front
// Position differences, squared distance and CORDIC pre-rotation.
// ----------------------------------------------------------------------------
module vcs_front import vcs_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [POS_W-1:0]        i_self_x,
    input  logic [POS_W-1:0]        i_self_y,
    input  logic [HEAD_W-1:0]       i_self_heading,
    input  logic [POS_W-1:0]        i_other_x,
    input  logic [POS_W-1:0]        i_other_y,
    input  logic [DIST_W-1:0]       i_max_dist_sq,
    output logic                    o_valid,
    output logic signed [CW-1:0]    o_x,
    output logic signed [CW-1:0]    o_y,
    output logic signed [ZW-1:0]    o_z,
    output t_side                   o_side
);

    // Stage 1: differences and reduced heading.
    logic                     r_f1_valid;
    logic signed [DIFF_W-1:0] r_dx, r_dy;
    logic [HEAD_W-1:0]        r_f1_head_in, r_f1_head;
    logic signed [DIFF_W-1:0] n_dx, n_dy;
    logic [HEAD_W-1:0]        n_head;

    // Stage 2: squares and pre-rotated vector.
    logic                     r_f2_valid;
    logic [SQ_W-1:0]          r_dxsq, r_dysq;
    logic signed [CW-1:0]     r_x, r_y;
    logic signed [ZW-1:0]     r_z;
    logic [HEAD_W-1:0]        r_f2_head_in, r_f2_head;

    logic signed [2*DIFF_W-1:0] w_sqx, w_sqy;
    logic signed [CW-1:0]     w_gx, w_gy, n_x, n_y;
    logic signed [ZW-1:0]     n_z;
    logic [DIST_W-1:0]        w_dist;

    always_comb begin
        n_dx   = $signed({1'b0, i_other_x}) - $signed({1'b0, i_self_x});
        n_dy   = $signed({1'b0, i_other_y}) - $signed({1'b0, i_self_y});
        n_head = (i_self_heading >= HEAD_W'(FULL_TURN)) ?
                 i_self_heading - HEAD_W'(FULL_TURN) : i_self_heading;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
        end else if (i_en) begin
            r_f1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx         <= n_dx;
            r_dy         <= n_dy;
            r_f1_head_in <= i_self_heading;
            r_f1_head    <= n_head;
        end
    end

    assign w_sqx = r_dx * r_dx;
    assign w_sqy = r_dy * r_dy;
    assign w_gx  = {{(CW-DIFF_W-GUARD_SHIFT){r_dx[DIFF_W-1]}}, r_dx, {GUARD_SHIFT{1'b0}}};
    assign w_gy  = {{(CW-DIFF_W-GUARD_SHIFT){r_dy[DIFF_W-1]}}, r_dy, {GUARD_SHIFT{1'b0}}};

    // Vectors in the left half plane are turned by a quarter turn first.
    always_comb begin
        n_x = w_gx;
        n_y = w_gy;
        n_z = '0;
        if (w_gx < 0) begin
            if (w_gy >= 0) begin
                n_x = w_gy;
                n_y = -w_gx;
                n_z = Z_QUARTER;
            end else begin
                n_x = -w_gy;
                n_y = w_gx;
                n_z = -Z_QUARTER;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f2_valid <= 1'b0;
        end else if (i_en) begin
            r_f2_valid <= r_f1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dxsq       <= w_sqx[SQ_W-1:0];
            r_dysq       <= w_sqy[SQ_W-1:0];
            r_x          <= n_x;
            r_y          <= n_y;
            r_z          <= n_z;
            r_f2_head_in <= r_f1_head_in;
            r_f2_head    <= r_f1_head;
        end
    end

    assign w_dist = {1'b0, r_dxsq} + {1'b0, r_dysq};

    always_comb begin
        o_side.head_in = r_f2_head_in;
        o_side.head    = r_f2_head;
        o_side.dist_ok = (w_dist <= i_max_dist_sq) && (w_dist >= NEAR_LIMIT);
    end

    assign o_valid = r_f2_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;

endmodule

// File: design/vcs_cordic_stage.sv
// ----------------------------------------------------------------------------
// vcs_cordic_stage
// One registered vectoring step of the arctangent CORDIC.
// ----------------------------------------------------------------------------
module vcs_cordic_stage import vcs_pkg::*; #(
    parameter int STAGE = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [CW-1:0] i_x,
    input  logic signed [CW-1:0] i_y,
    input  logic signed [ZW-1:0] i_z,
    input  t_side                i_side,
    output logic                 o_valid,
    output logic signed [CW-1:0] o_x,
    output logic signed [CW-1:0] o_y,
    output logic signed [ZW-1:0] o_z,
    output t_side                o_side
);

    localparam logic signed [ZW-1:0] ATAN = atan_val(STAGE);

    logic signed [CW-1:0] w_xs, w_ys, n_x, n_y;
    logic signed [ZW-1:0] n_z;
    logic                 r_valid;
    logic signed [CW-1:0] r_x, r_y;
    logic signed [ZW-1:0] r_z;
    t_side                r_side;

    assign w_xs = i_x >>> STAGE;
    assign w_ys = i_y >>> STAGE;

    // Rotate toward the x axis; a vector already on it stays put.
    always_comb begin
        n_x = i_x;
        n_y = i_y;
        n_z = i_z;
        if (i_y > 0) begin
            n_x = i_x + w_ys;
            n_y = i_y - w_xs;
            n_z = i_z + ATAN;
        end else if (i_y < 0) begin
            n_x = i_x - w_ys;
            n_y = i_y + w_xs;
            n_z = i_z - ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_side  = r_side;

endmodule

// File: design/vcs_back.sv
// ----------------------------------------------------------------------------
// vcs_back
// Bearing rounding, cone test, clamped turn and the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vcs_back import vcs_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [ZW-1:0] i_z,
    input  t_side                i_side,
    input  logic [ANG_W-1:0]     i_cone_limit,
    input  logic [ANG_W-1:0]     i_turn_step,
    output logic                 o_valid,
    output logic                 o_visible,
    output logic [HEAD_W-1:0]    o_new_heading
);

    localparam logic signed [AW-1:0] D_HALF = AW'(HALF_TURN);
    localparam logic signed [AW-1:0] D_FULL = AW'(FULL_TURN);

    logic signed [ZW-1:0] w_zr, w_zsh;
    logic signed [AW-1:0] w_d, n_d, w_abs, w_step, n_delta, w_nh, n_nh;
    logic                 n_vis;

    logic                 r_b1_valid, r_b2_valid, r_b3_valid, r_out_valid;
    logic signed [AW-1:0] r_b, r_d, r_delta;
    logic                 r_vis, r_visible;
    t_side                r_b1_side, r_b2_side, r_b3_side;
    logic [HEAD_W-1:0]    r_new_heading;

    // Stage 1: round the accumulator to 1/64 degree.
    assign w_zr  = i_z + ZW'(1 << (ACC_EXTRA - 1));
    assign w_zsh = w_zr >>> ACC_EXTRA;

    // Stage 2: signed bearing minus heading, folded into one half turn either way.
    always_comb begin
        w_d = r_b - $signed({{(AW-HEAD_W){1'b0}}, r_b1_side.head});
        if (w_d > D_HALF) begin
            n_d = w_d - D_FULL;
        end else if (w_d < -D_HALF) begin
            n_d = w_d + D_FULL;
        end else begin
            n_d = w_d;
        end
    end

    // Stage 3: cone test and the turn clamped to the step.
    always_comb begin
        w_abs  = (r_d < 0) ? -r_d : r_d;
        w_step = $signed({{(AW-ANG_W){1'b0}}, i_turn_step});
        n_vis  = r_b2_side.dist_ok && (w_abs <= $signed({{(AW-ANG_W){1'b0}}, i_cone_limit}));
        if (r_d > 0) begin
            n_delta = (r_d < w_step) ? r_d : w_step;
        end else begin
            n_delta = (r_d > -w_step) ? r_d : -w_step;
        end
    end

    // Stage 4: apply the turn and wrap once into a full turn.
    always_comb begin
        w_nh = $signed({{(AW-HEAD_W){1'b0}}, r_b3_side.head}) + r_delta;
        if (w_nh < 0) begin
            n_nh = w_nh + D_FULL;
        end else if (w_nh >= D_FULL) begin
            n_nh = w_nh - D_FULL;
        end else begin
            n_nh = w_nh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid  <= 1'b0;
            r_b2_valid  <= 1'b0;
            r_b3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_b1_valid  <= i_valid;
            r_b2_valid  <= r_b1_valid;
            r_b3_valid  <= r_b2_valid;
            r_out_valid <= r_b3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b           <= w_zsh[AW-1:0];
            r_b1_side     <= i_side;
            r_d           <= n_d;
            r_b2_side     <= r_b1_side;
            r_vis         <= n_vis;
            r_delta       <= n_delta;
            r_b3_side     <= r_b2_side;
            r_visible     <= r_vis;
            r_new_heading <= r_vis ? n_nh[HEAD_W-1:0] : r_b3_side.head_in;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_visible     = r_visible;
    assign o_new_heading = r_new_heading;

    `VCS_ASSERT(a_fold_range, i_clk, i_rst_n, r_b2_valid |-> (r_d <= D_HALF) && (r_d >= -D_HALF), "folded bearing difference outside half turn")
    `VCS_ASSERT(a_turn_clamp, i_clk, i_rst_n, r_b3_valid && r_vis |-> (r_delta <= w_step) && (r_delta >= -w_step), "heading change exceeds turn step")
    `VCS_ASSERT(a_out_advance, i_clk, i_rst_n, i_en |=> (r_out_valid == $past(r_b3_valid)), "output valid did not follow last stage")

endmodule

// File: design/view_cone_steer_top.sv
// ----------------------------------------------------------------------------
// view_cone_steer_top: sight test of one agent against another, with heading nudge
// Throughput: one item per cycle while no valid output is held by i_ready low;
// every stage is a register, the CORDIC one step each.
// Reset: synchronous active-low i_rst_n empties the pipeline and loads register defaults.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module view_cone_steer_top import vcs_pkg::*; #(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Configuration write port.
    input  logic                i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [DIST_W-1:0]   i_cfg_data,
    // Input channel.
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [POS_W-1:0]    i_self_x,
    input  logic [POS_W-1:0]    i_self_y,
    input  logic [HEAD_W-1:0]   i_self_heading,
    input  logic [POS_W-1:0]    i_other_x,
    input  logic [POS_W-1:0]    i_other_y,
    // Output channel.
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_visible,
    output logic [HEAD_W-1:0]   o_new_heading
);

    // The pipeline is one chain of registers that all move together. It
    // advances whenever the output register is empty or its transfer completes,
    // so a new input is taken in the same cycle that a result leaves. Each
    // stage carries its own valid bit, so bubbles simply flow through.
    //
    // Stage map:
    //   front   2 stages: differences, then squares and the quarter-turn
    //                     pre-rotation; the distance compare feeds CORDIC step 0.
    //   cordic  CORDIC_STAGES stages, one shift-add step each.
    //   back    4 stages: rounding, bearing fold, cone test with clamp,
    //                     and the output register with the wrapped heading.

    logic               w_en;
    logic [DIST_W-1:0]  r_max_dist_sq;
    logic [ANG_W-1:0]   r_cone_limit;
    logic [ANG_W-1:0]   r_turn_step;

    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;

    // Configuration registers. The user must make writes only while the block is
    // idle (unchecked); the pipeline reads them directly. Unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_dist_sq <= DIST_W'(409600);
            r_cone_limit  <= ANG_W'(5760);
            r_turn_step   <= ANG_W'(64);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_MAX_DIST_SQ: r_max_dist_sq <= i_cfg_data;
                CFG_CONE_LIMIT:  r_cone_limit  <= i_cfg_data[ANG_W-1:0];
                CFG_TURN_STEP:   r_turn_step   <= i_cfg_data[ANG_W-1:0];
                default: ;
            endcase
        end
    end

    // Per-step CORDIC vector; entry 0 comes from the front end.
    logic                 w_cv [CORDIC_STAGES+1];
    logic signed [CW-1:0] w_cx [CORDIC_STAGES+1];
    logic signed [CW-1:0] w_cy [CORDIC_STAGES+1];
    logic signed [ZW-1:0] w_cz [CORDIC_STAGES+1];
    t_side                w_cs [CORDIC_STAGES+1];

    vcs_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_en),
        .i_valid        (i_valid),
        .i_self_x       (i_self_x),
        .i_self_y       (i_self_y),
        .i_self_heading (i_self_heading),
        .i_other_x      (i_other_x),
        .i_other_y      (i_other_y),
        .i_max_dist_sq  (r_max_dist_sq),
        .o_valid        (w_cv[0]),
        .o_x            (w_cx[0]),
        .o_y            (w_cy[0]),
        .o_z            (w_cz[0]),
        .o_side         (w_cs[0])
    );

    // The y component is driven toward zero; the accumulated angle is the
    // bearing. The vector magnitude is never used, so the CORDIC gain is
    // left in and only sets the datapath width.
    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
        vcs_cordic_stage #(
            .STAGE (g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_cv[g]),
            .i_x     (w_cx[g]),
            .i_y     (w_cy[g]),
            .i_z     (w_cz[g]),
            .i_side  (w_cs[g]),
            .o_valid (w_cv[g+1]),
            .o_x     (w_cx[g+1]),
            .o_y     (w_cy[g+1]),
            .o_z     (w_cz[g+1]),
            .o_side  (w_cs[g+1])
        );
    end

    // The final x and y components are not needed past the last step.
    vcs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_en),
        .i_valid       (w_cv[CORDIC_STAGES]),
        .i_z           (w_cz[CORDIC_STAGES]),
        .i_side        (w_cs[CORDIC_STAGES]),
        .i_cone_limit  (r_cone_limit),
        .i_turn_step   (r_turn_step),
        .o_valid       (o_valid),
        .o_visible     (o_visible),
        .o_new_heading (o_new_heading)
    );

    // A nudged heading is always wrapped into a full turn.
    `VCS_ASSERT(a_nudge_wrapped, i_clk, i_rst_n, o_valid && o_visible |-> (o_new_heading < HEAD_W'(FULL_TURN)), "nudged heading not wrapped")

endmodule
